>>> design/ifc_pkg.sv
// Shared types, constants and helper functions for the incremental fuzzy controller.
package ifc_pkg;

  localparam int DataW  = 32;
  localparam int WideW  = 36;
  localparam int MuW    = 21;
  localparam int NumW   = 56;
  localparam int WsumW  = 24;
  localparam int StepW  = 6;
  localparam int CfgIdxW = 3;

  localparam logic [MuW-1:0] MU_ONE = MuW'(1 << 20);

  localparam logic [CfgIdxW-1:0] REG_ERROR_HW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DIFF_HW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SECOND_HW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OUT_NEG    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_ZERO   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OUT_POS    = 3'd6;

  localparam logic [1:0] LBL_N = 2'd0;
  localparam logic [1:0] LBL_Z = 2'd1;
  localparam logic [1:0] LBL_P = 2'd2;

  localparam logic [StepW-1:0] FUZZ_STEPS = 6'd20;
  localparam logic [StepW-1:0] DEFUZZ_STEPS = 6'd32;

  typedef struct packed {
    logic             start;
    logic [StepW-1:0] steps;
    logic [WideW-1:0] hi;
    logic [DataW-1:0] lo;
    logic [WideW-1:0] den;
  } div_req_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[DataW-1:0];
    return r;
  endfunction

  function automatic logic [1:0] rule_label(input logic [1:0] de, input logic [1:0] ee);
    logic [1:0] r;
    case (de)
      LBL_N:   r = (ee == LBL_P) ? LBL_P : LBL_N;
      LBL_Z:   r = ee;
      default: r = (ee == LBL_N) ? LBL_N : LBL_P;
    endcase
    return r;
  endfunction

endpackage

>>> design/ifc_divider.sv
// Restoring divider, one quotient bit per cycle.
module ifc_divider (
  input  logic             clk,
  input  logic             rst,
  input  ifc_pkg::div_req_t req,
  output logic             done,
  output logic [ifc_pkg::DataW-1:0] quot
);
  import ifc_pkg::*;

  logic             busy;
  logic [StepW-1:0] cnt;
  logic [WideW:0]   rem;
  logic [DataW-1:0] low;
  logic [WideW-1:0] den;
  logic [WideW:0]   trial;
  logic             ge;

  assign trial = {rem[WideW-1:0], low[DataW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= {1'b0, req.hi};
        low  <= req.lo;
        den  <= req.den;
        quot <= '0;
      end else if (busy) begin
        rem  <= ge ? (trial - {1'b0, den}) : trial;
        quot <= {quot[DataW-2:0], ge};
        low  <= {low[DataW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == 6'd1) |=> done)
    else $error("divider missed done");

endmodule

>>> design/incremental_fuzzy_controller.sv
// Incremental fuzzy PID controller top level: sequencer, shared multiplier, state.
// From accept to result: three membership divisions (skipped when a value sits on or
// beyond a breakpoint), eight weight passes through the one multiplier, and a quotient
// for the increment. s_tready is high only while idle, so a new request is taken only
// after the previous result is loaded, and a held result stalls the sequencer.
// Synchronous reset restores register defaults.
module incremental_fuzzy_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // reference_sample [31:0], plant_sample [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // drive [31:0], drive_step [63:32]
  input  logic        cfg_we,
  input  logic [ifc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ifc_pkg::DataW-1:0]   cfg_data
);
  import ifc_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DIFF  = 16'h0002,
    S_DD    = 16'h0004,
    S_CMUL  = 16'h0008,
    S_CENT  = 16'h0010,
    S_FZSET = 16'h0020,
    S_FZDIV = 16'h0040,
    S_WMA   = 16'h0080,
    S_WMB   = 16'h0100,
    S_WMC   = 16'h0200,
    S_WWT   = 16'h0400,
    S_WMS   = 16'h0800,
    S_WACC  = 16'h1000,
    S_DIVF  = 16'h2000,
    S_DIVW  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  state_t state;

  logic [30:0] error_hw, diff_hw, second_hw;
  logic [16:0] scale;
  logic signed [DataW-1:0] out_neg, out_zero, out_pos;

  logic signed [DataW-1:0] err, diff, dd, last_err, last_diff, drive_total, inc;
  logic signed [WideW-1:0] centre;
  logic [MuW-1:0] mu [3][2];
  logic [2:0] lbl_hi;
  logic [1:0] fz;
  logic [2:0] idx;
  logic [MuW-1:0] phi, wt;
  logic [41:0] plo;
  logic signed [NumW-1:0] num;
  logic [WsumW-1:0] wsum;
  logic num_neg;

  logic signed [21:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [54:0] prod;

  div_req_t div_req;
  logic div_done;
  logic [DataW-1:0] quot;

  logic signed [WideW-1:0] ref_x, plant_x, x_sel, w_sel, c_sel;
  logic signed [48:0] cprod, cadj;
  logic [62:0] wfull;
  logic [MuW-1:0] m_a, m_b, m_c;
  logic [1:0] rl;
  logic signed [DataW-1:0] single;
  logic [NumW-1:0] mag;
  logic signed [WideW-1:0] qs, drive_sum;
  logic interior;
  logic [WideW-1:0] fz_num, fz_den;
  logic fz_hi;

  assign s_tready = (state == S_IDLE);

  assign ref_x   = {{4{s_tdata[31]}}, s_tdata[31:0]};
  assign plant_x = {{4{s_tdata[63]}}, s_tdata[63:32]};
  assign cprod   = prod[48:0];
  assign cadj    = cprod + (cprod[48] ? 49'sd65535 : 49'sd0);
  assign wfull   = {prod[41:0], 21'd0} + {21'd0, plo};

  assign m_a = mu[0][idx[2]];
  assign m_b = mu[1][idx[1]];
  assign m_c = mu[2][idx[0]];
  assign rl  = rule_label({1'b0, lbl_hi[1]} + {1'b0, idx[1]},
                          {1'b0, lbl_hi[0]} + {1'b0, idx[2]});

  always_comb begin
    case (rl)
      LBL_N:   single = out_neg;
      LBL_Z:   single = out_zero;
      default: single = out_pos;
    endcase
  end

  always_comb begin
    case (fz)
      2'd1: begin
        x_sel = {{4{diff[31]}}, diff};
        w_sel = {5'd0, diff_hw};
        c_sel = '0;
      end
      2'd2: begin
        x_sel = {{4{dd[31]}}, dd};
        w_sel = {5'd0, second_hw};
        c_sel = '0;
      end
      default: begin
        x_sel = {{4{err[31]}}, err};
        w_sel = {5'd0, error_hw};
        c_sel = centre;
      end
    endcase
  end

  always_comb begin
    interior = 1'b0;
    fz_hi    = 1'b0;
    fz_num   = '0;
    fz_den   = '0;
    if (x_sel <= -w_sel) begin
      fz_hi = 1'b0;
    end else if (x_sel < c_sel) begin
      interior = 1'b1;
      fz_num   = x_sel + w_sel;
      fz_den   = c_sel + w_sel;
    end else if (x_sel == c_sel) begin
      fz_hi = 1'b0;
    end else if (x_sel < w_sel) begin
      interior = 1'b1;
      fz_hi    = 1'b1;
      fz_num   = x_sel - c_sel;
      fz_den   = w_sel - c_sel;
    end else begin
      fz_hi = 1'b1;
    end
  end

  assign mag = num[NumW-1] ? NumW'(-num) : NumW'(num);

  always_comb begin
    div_req = '0;
    if (state == S_FZSET && interior) begin
      div_req.start = 1'b1;
      div_req.steps = FUZZ_STEPS;
      div_req.hi    = fz_num;
      div_req.den   = fz_den;
    end else if (state == S_DIVF) begin
      div_req.start = 1'b1;
      div_req.steps = DEFUZZ_STEPS;
      div_req.hi    = {12'd0, mag[55:32]};
      div_req.lo    = mag[31:0];
      div_req.den   = {12'd0, wsum};
    end
  end

  ifc_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CMUL: begin
        mul_a = {5'd0, scale};
        mul_b = {err[31], err};
      end
      S_WMA: begin
        mul_a = {1'b0, m_a};
        mul_b = {12'd0, m_b};
      end
      S_WMB: begin
        mul_a = {1'b0, prod[20:0]};
        mul_b = {12'd0, m_c};
      end
      S_WMC: begin
        mul_a = {1'b0, phi};
        mul_b = {12'd0, m_c};
      end
      S_WMS: begin
        mul_a = {1'b0, wt};
        mul_b = {single[31], single};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign qs        = num_neg ? -{4'd0, quot} : {4'd0, quot};
  assign drive_sum = {{4{drive_total[31]}}, drive_total} + {{4{inc[31]}}, inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      error_hw  <= 31'd1048576;
      diff_hw   <= 31'd1048576;
      second_hw <= 31'd1048576;
      scale     <= 17'd65536;
      out_neg   <= -32'sd10485760;
      out_zero  <= '0;
      out_pos   <= 32'sd10485760;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ERROR_HW:  error_hw  <= cfg_data[30:0];
        REG_DIFF_HW:   diff_hw   <= cfg_data[30:0];
        REG_SECOND_HW: second_hw <= cfg_data[30:0];
        REG_SCALE:     scale     <= cfg_data[16:0];
        REG_OUT_NEG:   out_neg   <= cfg_data;
        REG_OUT_ZERO:  out_zero  <= cfg_data;
        REG_OUT_POS:   out_pos   <= cfg_data;
        default:       scale     <= scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_err    <= '0;
      last_diff   <= '0;
      drive_total <= '0;
      m_tvalid    <= 1'b0;
      fz          <= '0;
      idx         <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            err   <= sat32(ref_x - plant_x);
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff  <= sat32({{4{err[31]}}, err} - {{4{last_err[31]}}, last_err});
          state <= S_DD;
        end
        S_DD: begin
          dd        <= sat32({{4{diff[31]}}, diff} - {{4{last_diff[31]}}, last_diff});
          last_err  <= err;
          last_diff <= diff;
          state     <= S_CMUL;
        end
        S_CMUL: begin
          state <= S_CENT;
        end
        S_CENT: begin
          centre <= (scale == 17'd65536) ? '0 : WideW'(cadj >>> 16);
          fz     <= '0;
          state  <= S_FZSET;
        end
        S_FZSET: begin
          lbl_hi[fz] <= fz_hi;
          if (interior) begin
            state <= S_FZDIV;
          end else begin
            mu[fz][0] <= (x_sel <= -w_sel) ? MU_ONE : '0;
            mu[fz][1] <= (x_sel <= -w_sel) ? '0 : MU_ONE;
            fz        <= fz + 1'b1;
            if (fz == 2'd2) begin
              idx   <= '0;
              num   <= '0;
              wsum  <= '0;
              state <= S_WMA;
            end
          end
        end
        S_FZDIV: begin
          if (div_done) begin
            mu[fz][1] <= {1'b0, quot[19:0]};
            mu[fz][0] <= MU_ONE - {1'b0, quot[19:0]};
            fz        <= fz + 1'b1;
            if (fz == 2'd2) begin
              idx   <= '0;
              num   <= '0;
              wsum  <= '0;
              state <= S_WMA;
            end else begin
              state <= S_FZSET;
            end
          end
        end
        S_WMA: state <= S_WMB;
        S_WMB: begin
          phi   <= prod[41:21];
          state <= S_WMC;
        end
        S_WMC: begin
          plo   <= prod[41:0];
          state <= S_WWT;
        end
        S_WWT: begin
          wt    <= wfull[60:40];
          state <= S_WMS;
        end
        S_WMS: state <= S_WACC;
        S_WACC: begin
          num  <= num + {prod[54], prod};
          wsum <= wsum + {3'd0, wt};
          idx  <= idx + 1'b1;
          state <= (idx == 3'd7) ? S_DIVF : S_WMA;
        end
        S_DIVF: begin
          num_neg <= num[NumW-1];
          state   <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            inc   <= sat32(qs);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            drive_total <= sat32(drive_sum);
            m_tdata     <= {inc, sat32(drive_sum)};
            m_tvalid    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("accepted a request but stayed ready");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FZDIV || state == S_DIVW))
    else $error("divider result with no consumer");
  a_wsum_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVF) |-> (wsum >= 24'd1048568))
    else $error("weight sum below bound");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
    else $error("result not presented");

endmodule
